// ===== rtl/tte_pkg.sv =====
`default_nettype none

package tte_pkg;

   localparam int TEMP_W    = 14;
   localparam int EMF_W     = 16;
   localparam int ACC_W     = 64;
   localparam int NUM_CELLS = 14;   // one Horner multiply per cell
   localparam int POS_TERMS = 8;
   localparam int WIDE_W    = 256;  // scratch width for coefficient prescaling

   localparam logic signed [TEMP_W-1:0] T_MIN_SIXTEENTHS = -14'sd4320;
   localparam logic signed [TEMP_W-1:0] T_MAX_SIXTEENTHS = 14'sd6400;

   // Coefficient i+1 is mantissa * 10^-div, in mV per degC^(i+1).
   localparam longint NEG_MANT [NUM_CELLS] = '{
      64'sd38748106364, 64'sd44194434347, 64'sd11844323105, 64'sd20032973554,
      64'sd90138019559, 64'sd22651156593, 64'sd36071154205, 64'sd38493939883,
      64'sd28213521925, 64'sd14251594779, 64'sd48768662286, 64'sd10795539270,
      64'sd13945027062, 64'sd79795153927};
   localparam int NEG_DIV [NUM_CELLS] = '{
      12, 15, 17, 18, 20, 21, 23, 25, 27, 29, 32, 34, 37, 41};
   localparam longint POS_MANT [POS_TERMS] = '{
      64'sd38748106364, 64'sd33292227880, 64'sd20618243404, -64'sd21882256846,
      64'sd10996880928, -64'sd30815758772, 64'sd45479135290, -64'sd27512901673};
   localparam int POS_DIV [POS_TERMS] = '{12, 15, 17, 19, 21, 24, 27, 30};

   // round(mant * 2^(9*power+32) / 10^div_exp), half away from zero.
   // Elaboration only.
   function automatic logic signed [ACC_W-1:0] scale_coef(input longint mant,
                                                          input int power,
                                                          input int div_exp);
      logic [WIDE_W-1:0] w;
      logic [ACC_W:0]    q;
      logic [ACC_W-1:0]  mag;
      mag = (mant < 0) ? ACC_W'(-mant) : ACC_W'(mant);
      w   = {{(WIDE_W-ACC_W){1'b0}}, mag} << (9 * power + 33);
      for (int d = 0; d < div_exp; d++) begin
         w = w / 10;
      end
      q = ({1'b0, w[ACC_W-1:0]} + (ACC_W+1)'(1)) >> 1;
      return (mant < 0) ? -$signed(q[ACC_W-1:0]) : $signed(q[ACC_W-1:0]);
   endfunction

   // Positive range has fewer terms; the high ones are padded with zero.
   function automatic logic signed [ACC_W-1:0] coef_of(input logic neg, input int idx);
      if (neg) begin
         return scale_coef(NEG_MANT[idx], idx + 1, NEG_DIV[idx]);
      end else if (idx < POS_TERMS) begin
         return scale_coef(POS_MANT[idx], idx + 1, POS_DIV[idx]);
      end
      return '0;
   endfunction

   localparam logic signed [ACC_W-1:0] NEG_COEF [NUM_CELLS] = '{
      coef_of(1'b1, 0),  coef_of(1'b1, 1),  coef_of(1'b1, 2),  coef_of(1'b1, 3),
      coef_of(1'b1, 4),  coef_of(1'b1, 5),  coef_of(1'b1, 6),  coef_of(1'b1, 7),
      coef_of(1'b1, 8),  coef_of(1'b1, 9),  coef_of(1'b1, 10), coef_of(1'b1, 11),
      coef_of(1'b1, 12), coef_of(1'b1, 13)};
   localparam logic signed [ACC_W-1:0] POS_COEF [NUM_CELLS] = '{
      coef_of(1'b0, 0),  coef_of(1'b0, 1),  coef_of(1'b0, 2),  coef_of(1'b0, 3),
      coef_of(1'b0, 4),  coef_of(1'b0, 5),  coef_of(1'b0, 6),  coef_of(1'b0, 7),
      coef_of(1'b0, 8),  coef_of(1'b0, 9),  coef_of(1'b0, 10), coef_of(1'b0, 11),
      coef_of(1'b0, 12), coef_of(1'b0, 13)};

   // Per-item control that rides along the cell chain.
   typedef struct packed {
      logic                     neg;    // negative-range polynomial
      logic                     blank;  // result forced to zero
      logic                     oor;    // out of range
      logic signed [TEMP_W-1:0] temp;
   } tag_type;

endpackage

`default_nettype wire

// ===== rtl/tte_cell.sv =====
`default_nettype none

module tte_cell (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic                                valid_in,
   input  wire tte_pkg::tag_type                    tag_in,
   input  wire logic signed [tte_pkg::ACC_W-1:0]    acc_in,
   input  wire logic signed [tte_pkg::ACC_W-1:0]    add_neg,
   input  wire logic signed [tte_pkg::ACC_W-1:0]    add_pos,
   output logic                                     valid_out,
   output tte_pkg::tag_type                         tag_out,
   output logic signed [tte_pkg::ACC_W-1:0]         acc_out
);

   localparam int PROD_W = tte_pkg::ACC_W + tte_pkg::TEMP_W;

   logic                                valid_ff;
   tte_pkg::tag_type                    tag_ff;
   logic signed [tte_pkg::ACC_W-1:0]    acc_ff;
   logic signed [tte_pkg::ACC_W-1:0]    acc_in_next;

   logic [tte_pkg::ACC_W-1:0]  acc_mag;
   logic [tte_pkg::TEMP_W-1:0] temp_mag;
   logic [PROD_W-1:0]          prod;
   logic [tte_pkg::ACC_W-1:0]  prod_rnd;
   logic signed [tte_pkg::ACC_W-1:0] scaled;

   // acc * t / 8192 rounded half away from zero, on magnitudes, plus the range's coefficient
   always_comb begin
      acc_mag  = acc_in[tte_pkg::ACC_W-1] ? tte_pkg::ACC_W'(-acc_in)
                                          : tte_pkg::ACC_W'(acc_in);
      temp_mag = tag_in.temp[tte_pkg::TEMP_W-1] ? tte_pkg::TEMP_W'(-tag_in.temp)
                                                : tte_pkg::TEMP_W'(tag_in.temp);
      prod     = {{tte_pkg::TEMP_W{1'b0}}, acc_mag} *
                 {{tte_pkg::ACC_W{1'b0}}, temp_mag};
      prod     = prod + PROD_W'(4096);
      prod_rnd = prod[tte_pkg::ACC_W+12:13];
      scaled   = (acc_in[tte_pkg::ACC_W-1] ^ tag_in.temp[tte_pkg::TEMP_W-1])
                 ? -$signed(prod_rnd) : $signed(prod_rnd);
      acc_in_next = scaled + (tag_in.neg ? add_neg : add_pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff <= tag_in;
         acc_ff <= acc_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign tag_out   = tag_ff;
   assign acc_out   = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/tte_scale.sv =====
`default_nettype none

module tte_scale (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              valid_in,
   input  wire tte_pkg::tag_type                  tag_in,
   input  wire logic signed [tte_pkg::ACC_W-1:0]  acc_in,
   output logic                                   rsp_valid,
   output logic signed [tte_pkg::EMF_W-1:0]       rsp_emf_microvolts,
   output logic                                   rsp_out_of_range
);

   localparam int SCALE_W = tte_pkg::ACC_W + 10;

   logic                              rsp_valid_ff;
   logic signed [tte_pkg::EMF_W-1:0]  emf_ff;
   logic signed [tte_pkg::EMF_W-1:0]  emf_in;
   logic                              oor_ff;

   logic [tte_pkg::ACC_W-1:0] acc_mag;
   logic [SCALE_W-1:0]        uv_wide;
   logic [tte_pkg::EMF_W-1:0] uv;

   // mV * 2^32 -> uV, rounded half away from zero
   always_comb begin
      acc_mag = acc_in[tte_pkg::ACC_W-1] ? tte_pkg::ACC_W'(-acc_in)
                                         : tte_pkg::ACC_W'(acc_in);
      uv_wide = {10'd0, acc_mag} * SCALE_W'(1000) + SCALE_W'(64'h8000_0000);
      uv      = uv_wide[32 +: tte_pkg::EMF_W];
      if (tag_in.blank) begin
         emf_in = '0;
      end else if (acc_in[tte_pkg::ACC_W-1]) begin
         emf_in = -$signed(uv);
      end else begin
         emf_in = $signed(uv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         emf_ff <= emf_in;
         oor_ff <= tag_in.oor;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_emf_microvolts = emf_ff;
   assign rsp_out_of_range   = oor_ff;

`ifndef ASSERT_OFF
   // EMF sign follows temperature sign over the whole table range
   a_acc_sign: assert property (@(posedge clock) disable iff (reset)
      valid_in && !tag_in.blank |->
         (tag_in.neg ? (acc_in <= 0) : (acc_in >= 0)))
      else $error("accumulator sign does not match temperature range");
`endif

endmodule

`default_nettype wire

// ===== rtl/type_t_thermocouple_emf.sv =====
`default_nettype none

// Type T thermocouple EMF (uV) from temperature (1/16 degC).
// Each item passes through 14 Horner cells and then one output scaling register,
// and is held in place only while the result side stalls.
// Throughput: one item per cycle while the result side does not stall; the cell chain advances as a whole.
// Synchronous reset clears all valid bits; no results pending after reset.

module type_t_thermocouple_emf (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [tte_pkg::TEMP_W-1:0]   req_temp_sixteenths,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [tte_pkg::EMF_W-1:0]         rsp_emf_microvolts,
   output logic                                     rsp_out_of_range
);

   localparam int N = tte_pkg::NUM_CELLS;

   logic                              advance;
   logic                              valid_c [N+1];
   tte_pkg::tag_type                  tag_c   [N+1];
   logic signed [tte_pkg::ACC_W-1:0]  acc_c   [N+1];

   // chain moves unless a finished result is held
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      tag_c[0].neg   = req_temp_sixteenths[tte_pkg::TEMP_W-1];
      tag_c[0].oor   = (req_temp_sixteenths < tte_pkg::T_MIN_SIXTEENTHS) ||
                       (req_temp_sixteenths > tte_pkg::T_MAX_SIXTEENTHS);
      tag_c[0].blank = tag_c[0].oor || (req_temp_sixteenths == '0);
      tag_c[0].temp  = req_temp_sixteenths;
      acc_c[0]       = tag_c[0].neg ? tte_pkg::NEG_COEF[N-1] : tte_pkg::POS_COEF[N-1];
   end
   assign valid_c[0] = req_valid;

   for (genvar k = 0; k < N; k++) begin : g_cell
      logic signed [tte_pkg::ACC_W-1:0] add_neg;
      logic signed [tte_pkg::ACC_W-1:0] add_pos;

      // last cell is the final multiply with no constant term
      if (k < N - 1) begin : g_term
         assign add_neg = tte_pkg::NEG_COEF[N-2-k];
         assign add_pos = tte_pkg::POS_COEF[N-2-k];
      end else begin : g_last
         assign add_neg = '0;
         assign add_pos = '0;
      end

      tte_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (valid_c[k]),
         .tag_in    (tag_c[k]),
         .acc_in    (acc_c[k]),
         .add_neg   (add_neg),
         .add_pos   (add_pos),
         .valid_out (valid_c[k+1]),
         .tag_out   (tag_c[k+1]),
         .acc_out   (acc_c[k+1])
      );
   end

   tte_scale u_scale (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .valid_in           (valid_c[N]),
      .tag_in             (tag_c[N]),
      .acc_in             (acc_c[N]),
      .rsp_valid          (rsp_valid),
      .rsp_emf_microvolts (rsp_emf_microvolts),
      .rsp_out_of_range   (rsp_out_of_range)
   );

`ifndef ASSERT_OFF
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_emf_microvolts == '0)
      else $error("out-of-range result carries nonzero EMF");

   a_chain_drain: assert property (@(posedge clock) disable iff (reset)
      valid_c[N] && advance |=> rsp_valid)
      else $error("item leaving the cell chain was dropped");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      valid_c[N] && req_stall |=> valid_c[N])
      else $error("last cell lost its item while the chain was held");
`endif

endmodule

`default_nettype wire
